FILE: src/sha_pkg.sv
// SHA-256 stream hasher package: FSM state type, controller/datapath command
// and status structs, round constants and initial hash values. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       buf_write;  // store in_byte at fill pointer
    logic       pad_start;  // write 0x80 at fill, clear rest of block
    logic       pad_len;    // write bit length into last 8 bytes
    logic       pad_zero;   // clear bytes 0..55 (extra length block)
    logic       load;       // working vars <= hash words
    logic       round;      // one compression round
    logic       add;        // hash words += working vars
    logic       add_bits;   // bit count += 512
    logic       restart;    // hash/count/fill back to initial
    logic       emit_shift; // step output word pointer
  } cmd_t;

  typedef struct packed {
    logic       block_full;  // fill wrapped to zero on this write
    logic       fill_ge56;
    logic       round_last;
  } status_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [9:0] BlockBits = 10'd512;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
  };

endpackage

FILE: src/sha_datapath.sv
// SHA-256 datapath: block buffer, schedule window, working variables, hash
// words, bit counter and digest output word selection. Uses sha_pkg.
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::cmd_t    cmd,
  input  logic [7:0]       in_byte,
  input  logic             in_present,
  output sha_pkg::status_t status,
  output logic [31:0]      out_word,
  output logic [2:0]       out_index
);

  // block held as 16 big-endian words; byte 4*k sits in bits [31:24] of word k
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [31:0] hash [8];
  logic [31:0] wv [8];
  logic [31:0] sched [16];
  logic [5:0]  rnd;
  logic [2:0]  emit_idx;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w, w15, w2, s0, s1, t1, t2;
  logic [63:0] total;
  logic [3:0]  r4;

  always_comb begin
    r4  = rnd[3:0];
    w15 = sched[4'(r4 - 4'd15)];
    w2  = sched[4'(r4 - 4'd2)];
    s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    if (rnd < 6'd16) begin
      w = blk[r4];
    end else begin
      w = s1 + sched[4'(r4 - 4'd7)] + s0 + sched[r4];
    end
    t1 = wv[7] + (ror(wv[4], 6) ^ ror(wv[4], 11) ^ ror(wv[4], 25)) +
         ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + sha_pkg::RoundK[rnd] + w;
    t2 = (ror(wv[0], 2) ^ ror(wv[0], 13) ^ ror(wv[0], 22)) +
         ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    total = bit_count + {55'd0, fill, 3'd0};
  end

  assign status.block_full = in_present && (fill == 6'd63);
  assign status.fill_ge56  = fill >= 6'd56;
  assign status.round_last = rnd == 6'd63;
  assign out_word  = hash[emit_idx];
  assign out_index = emit_idx;

  always_ff @(posedge clk) begin
    if (cmd.buf_write && in_present) blk[fill[5:2]][{~fill[1:0], 3'd0} +: 8] <= in_byte;
    if (cmd.pad_start) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 4; j++) begin
          if ({4'(i), 2'(j)} == fill) blk[4'(i)][8*(3-j) +: 8] <= sha_pkg::PadByte;
          else if ({4'(i), 2'(j)} > fill) blk[4'(i)][8*(3-j) +: 8] <= 8'd0;
        end
      end
    end
    if (cmd.pad_zero) begin
      for (int i = 0; i < 14; i++) blk[4'(i)] <= 32'd0;
    end
    if (cmd.pad_len) begin
      blk[4'd14] <= total[63:32];
      blk[4'd15] <= total[31:0];
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash[i];
    end
    if (cmd.round) begin
      sched[r4] <= w;
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::InitHash[i];
      bit_count <= 64'd0;
      fill      <= 6'd0;
      rnd       <= 6'd0;
      emit_idx  <= 3'd0;
    end else begin
      if (cmd.buf_write && in_present) fill <= fill + 6'd1;
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
      end
      if (cmd.add_bits) bit_count <= bit_count + {54'd0, sha_pkg::BlockBits};
      if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.emit_shift) emit_idx <= emit_idx + 3'd1;
    end
  end

endmodule

FILE: src/sha_control.sv
// SHA-256 controller FSM: sequences byte intake, compression rounds, padding
// and digest emission. Uses sha_pkg; drives sha_datapath commands.
module sha_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_end,
  output logic             in_ready,
  input  sha_pkg::status_t status,
  output sha_pkg::cmd_t    cmd,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             out_last
);

  sha_pkg::state_t state, state_next;
  logic final_blk, final_blk_next;  // compressing the block that ends the message
  logic fin, fin_next;              // end pending after current compression
  logic len_done, len_done_next;    // length already written into block

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      final_blk <= 1'b0;
      fin <= 1'b0;
      len_done <= 1'b0;
    end else begin
      state <= state_next;
      final_blk <= final_blk_next;
      fin <= fin_next;
      len_done <= len_done_next;
    end
  end

  always_comb begin
    state_next = state;
    final_blk_next = final_blk;
    fin_next = fin;
    len_done_next = len_done;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.buf_write = 1'b1;
          if (status.block_full) begin
            fin_next = in_end;
            final_blk_next = 1'b0;
            state_next = sha_pkg::ST_LOAD;
          end else if (in_end) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        cmd.pad_start = 1'b1;
        len_done_next = 1'b0;
        final_blk_next = !status.fill_ge56;
        state_next = sha_pkg::ST_LOAD;
      end
      sha_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        // length goes into the final block's last bytes before rounds read them
        if (final_blk && !len_done) begin
          cmd.pad_len = 1'b1;
          len_done_next = 1'b1;
        end
        state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_last) state_next = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        if (final_blk) begin
          state_next = sha_pkg::ST_EMIT;
        end else if (fin) begin
          // full block then end: pad with fill at zero
          fin_next = 1'b0;
          cmd.add_bits = 1'b1;
          state_next = sha_pkg::ST_PAD;
        end else if (len_done || status.fill_ge56) begin
          // padding spilled: extra block of zeros plus length
          cmd.pad_zero = 1'b1;
          cmd.pad_len = 1'b1;
          len_done_next = 1'b1;
          final_blk_next = 1'b1;
          state_next = sha_pkg::ST_LOAD;
        end else begin
          cmd.add_bits = 1'b1;
          state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_shift = 1'b1;
          if (out_last) begin
            cmd.restart = 1'b1;
            final_blk_next = 1'b0;
            len_done_next = 1'b0;
            state_next = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/sha256_stream_hasher.sv
// Channel  | dir | tdata                         | tuser | tlast
// s_axis   | in  | [7:0] data_byte               | [0] byte_present | end_of_message
// m_axis   | out | [31:0] digest_word             | [2:0] word_index | last_word
//
// Bytes are taken one per cycle while idle; a full block is then compressed
// (load, 64 rounds of the single round unit, add). End of message adds pad plus
// one or two compressions, then eight digest words, one per cycle when not stalled.
// Input is not accepted during compression or digest output; rst is synchronous.
// Top level: joins sha_control and sha_datapath. Uses sha_pkg.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);

  sha_pkg::cmd_t    cmd;
  sha_pkg::status_t status;

  sha_control u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_end(s_axis_tlast), .in_ready(s_axis_tready),
    .status(status), .cmd(cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_last(m_axis_tlast)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_byte(s_axis_tdata), .in_present(s_axis_tuser),
    .status(status), .out_word(m_axis_tdata), .out_index(m_axis_tuser)
  );

  assign m_axis_tlast = m_axis_tuser == 3'd7;

endmodule

FILE: src/sha_checker.sv
// Port-level checker for sha256_stream_hasher, bound to the top level.
// No package dependencies.
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during digest output");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast not on word 7");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

FILE: tb/testbench.sv
// Self-checking testbench for sha256_stream_hasher: streams message bytes, predicts
// SHA-256 digests with an in-bench model, and checks every digest word.
// Depends on the RTL top module and sha_pkg (round constants, initial hash).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  class digest_scoreboard;
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  bits;
    logic [31:0]  hv [8];
    digest_item_t pending [$];
    int unsigned  errors;
    int unsigned  messages;
    int unsigned  words_seen;

    function new();
      restart();
      errors = 0;
      messages = 0;
      words_seen = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hv[i] = sha_pkg::InitHash[i];
      fill = 0;
      bits = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int r = 0; r < 16; r++)
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++)
        w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
             + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      for (int i = 0; i < 8; i++) v[i] = hv[i];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[r] + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hv[i] += v[i];
    endfunction

    function void note_item(logic [7:0] data, logic present, logic eom);
      logic [63:0] total;
      digest_item_t d;
      if (present) begin
        blk[fill] = data;
        fill = (fill + 1) % 64;
        if (fill == 0) begin
          compress();
          bits += 64'd512;
        end
      end
      if (!eom) return;
      total = bits + 64'(fill * 8);
      blk[fill] = sha_pkg::PadByte;
      for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
      if (fill >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[63-i] = total[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = hv[i];
        d.index = 3'(i);
        d.last = (i == 7);
        pending.insert(pending.size(), d);
      end
      messages++;
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_item_t e;
      words_seen++;
      if (pending.size() == 0) begin
        $error("unexpected digest word %h", word);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
        $error("digest_word: expected %h, got %h", e.word, word);
        errors++;
      end
      if (index !== e.index) begin
        $error("word_index: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_word: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sha256_stream_hasher dut (.*);

  digest_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  // Slowest path: two compressions, 8 stalled words, plus long sender gaps.
  localparam int unsigned QuietLimit = 5000;
  // pad spill at 56 and at 63 bytes, and the spill again after one full block
  localparam int unsigned BoundLens [3] = '{56, 63, 120};

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no progress for %0d cycles", QuietLimit);
        $display("sha256_stream_hasher: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, decided at each falling edge.
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Returns at the accepting rising edge; valid stays up until the next call or drain.
  task automatic send_item(logic [7:0] data, logic present, logic eom);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tuser <= present;
    s_axis_tlast <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(data, present, eom);
    items_sent++;
  endtask

  task automatic send_message(int unsigned len, logic idle_noise);
    for (int i = 0; i < len; i++) begin
      if (idle_noise && $urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1)) begin
        send_item(8'($urandom), 1'b1, 1'b1);
        return;
      end
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int unsigned len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty message, single bytes at the extremes, idle items.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    drain();

    // Lengths around the pad boundary and the block edge.
    foreach (BoundLens[k]) send_message(BoundLens[k], 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      repeat (4) begin
        len = $urandom_range(0, 10);
        send_message(len, 1'b1);
      end
      drain();
    end

    $display("covered %0d items, %0d messages, %0d digest words",
             items_sent, sb.messages, sb.words_seen);
    $display("lengths 0..120 bytes incl. pad/block edges, under four idle/stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sha256_stream_hasher: match");
    else
      $display("sha256_stream_hasher: mismatch");
    $finish;
  end
endmodule
